// ===== rtl/ddo_pkg.sv =====
// shared types, constants and the arctangent table for the odometry block
// no dependencies
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned IDX_W  = 8;

  localparam logic [IDX_W-1:0] REG_DIST_PER_PULSE = 8'd0;
  localparam logic [IDX_W-1:0] REG_TURN_GAIN      = 8'd1;

  localparam logic [CFG_W-1:0] DIST_PER_PULSE_RST = 24'd661425;
  localparam logic [CFG_W-1:0] TURN_GAIN_RST      = 24'd45350;

  // 0.60725293 in q2.30, widened to the rotator width
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]        EIGHTH_TURN = 32'd536870912;

  typedef struct packed {
    logic signed [31:0] dr;
    logic signed [31:0] dl;
  } delta_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ddo_front.sv =====
// front end: takes encoder count requests and forms signed wheel deltas
// depends on ddo_pkg
module ddo_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // left_count[31:0], right_count[63:32]
  input  logic                  q_full,
  output logic                  push,
  output ddo_pkg::delta_t       push_data
);
  import ddo_pkg::*;

  logic [CNT_W-1:0] last_left;
  logic [CNT_W-1:0] last_right;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // wrapping difference read as signed motion
  assign push_data.dl = $signed(s_tdata[31:0] - last_left);
  assign push_data.dr = $signed(s_tdata[63:32] - last_right);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
    end else if (push) begin
      last_left  <= s_tdata[31:0];
      last_right <= s_tdata[63:32];
    end
  end

endmodule

// ===== rtl/ddo_queue.sv =====
// two-entry queue of wheel deltas between front and back end
// depends on ddo_pkg
module ddo_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ddo_pkg::delta_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output ddo_pkg::delta_t q_data
);
  import ddo_pkg::*;

  delta_t      slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/ddo_back.sv =====
// back end: travel products, cordic midpoint rotation, pose accumulation
// depends on ddo_pkg
module ddo_back #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  ddo_pkg::delta_t               q_data,
  output logic                          pop,
  input  logic [ddo_pkg::CFG_W-1:0]     dist_per_pulse,
  input  logic [ddo_pkg::CFG_W-1:0]     turn_gain,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [95:0]                   m_tdata    // pos_x, pos_y, heading
);
  import ddo_pkg::*;

  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MULT, S_TURN, S_ANGLE, S_CORD, S_ROT,
    S_XLO, S_XHI, S_XADD, S_YLO, S_YHI, S_YADD, S_DONE
  } state_t;

  state_t state;

  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [39:0] mean;
  logic signed [40:0] diff;
  logic [32:0]        turn;
  logic [31:0]        dtheta;
  logic [1:0]         quad;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [32:0] cz;
  logic [STEP_W-1:0]  step;
  logic signed [33:0] cos_v;
  logic signed [33:0] sin_v;
  logic signed [54:0] p_lo;
  logic signed [53:0] p_hi;
  logic [31:0]        x_new;
  logic [31:0]        y_new;
  logic [31:0]        x_acc;
  logic [31:0]        y_acc;
  logic [31:0]        theta_acc;

  logic signed [57:0] prod_m;
  logic signed [57:0] prod_d;
  logic [56:0]        prod_t;
  logic [31:0]        mid;
  logic [31:0]        shifted;
  logic signed [33:0] sx;
  logic signed [33:0] sy;
  logic signed [32:0] atan_v;
  logic signed [33:0] mul_sel;
  logic [63:0]        psum;

  assign prod_m  = sum * $signed({1'b0, dist_per_pulse});
  assign prod_d  = dif * $signed({1'b0, dist_per_pulse});
  assign prod_t  = diff[32:0] * turn_gain;
  assign mid     = theta_acc + turn[32:1];
  assign shifted = mid + EIGHTH_TURN;
  assign sx      = cx >>> step;
  assign sy      = cy >>> step;
  assign atan_v  = $signed({1'b0, atan_lut(5'(step))});
  assign mul_sel = (state == S_XLO || state == S_XHI) ? cos_v : sin_v;
  // product bits of mean * trig, low half unsigned, high half signed
  assign psum    = {{9{p_lo[54]}}, p_lo} + ({{10{p_hi[53]}}, p_hi} << 20);

  assign pop     = (state == S_IDLE) && q_valid;
  assign m_tdata = {theta_acc, y_acc, x_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      x_acc     <= '0;
      y_acc     <= '0;
      theta_acc <= '0;
      step      <= '0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            sum   <= 33'(q_data.dl) + 33'(q_data.dr);
            dif   <= 33'(q_data.dr) - 33'(q_data.dl);
            state <= S_MULT;
          end
        end
        S_MULT: begin
          mean  <= prod_m[56:17];
          diff  <= prod_d[56:16];
          state <= S_TURN;
        end
        S_TURN: begin
          turn  <= prod_t[32:0];
          state <= S_ANGLE;
        end
        S_ANGLE: begin
          dtheta <= turn[31:0];
          quad   <= shifted[31:30];
          cz     <= $signed({3'b000, shifted[29:0]}) - $signed({1'b0, EIGHTH_TURN});
          cx     <= CORDIC_GAIN;
          cy     <= '0;
          step   <= '0;
          state  <= S_CORD;
        end
        S_CORD: begin
          if (!cz[32]) begin
            cx <= cx - sy;
            cy <= cy + sx;
            cz <= cz - atan_v;
          end else begin
            cx <= cx + sy;
            cy <= cy - sx;
            cz <= cz + atan_v;
          end
          step <= step + 1'b1;
          if (step == LAST_STEP) state <= S_ROT;
        end
        S_ROT: begin
          case (quad)
            2'd0: begin cos_v <= cx;  sin_v <= cy;  end
            2'd1: begin cos_v <= -cy; sin_v <= cx;  end
            2'd2: begin cos_v <= -cx; sin_v <= -cy; end
            default: begin cos_v <= cy; sin_v <= -cx; end
          endcase
          state <= S_XLO;
        end
        S_XLO: begin
          p_lo  <= $signed({1'b0, mean[19:0]}) * mul_sel;
          state <= S_XHI;
        end
        S_XHI: begin
          p_hi  <= $signed(mean[39:20]) * mul_sel;
          state <= S_XADD;
        end
        S_XADD: begin
          x_new <= x_acc + psum[61:30];
          state <= S_YLO;
        end
        S_YLO: begin
          p_lo  <= $signed({1'b0, mean[19:0]}) * mul_sel;
          state <= S_YHI;
        end
        S_YHI: begin
          p_hi  <= $signed(mean[39:20]) * mul_sel;
          state <= S_YADD;
        end
        S_YADD: begin
          y_new <= y_acc + psum[61:30];
          state <= S_DONE;
        end
        S_DONE: begin
          // pose registers double as the output register
          if (!m_tvalid || m_tready) begin
            x_acc     <= x_new;
            y_acc     <= y_new;
            theta_acc <= theta_acc + dtheta;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// differential drive odometry, top level: config registers, front, queue, back
// the back end sequencer and its shared cordic rotator finish one request before taking
// the next; the queue between front and back end holds up to two requests
// reset clears pose, last counts and queue, and reloads the config defaults
// depends on ddo_pkg, ddo_front, ddo_queue, ddo_back
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [63:0]               s_tdata,   // left_count, right_count
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [95:0]               m_tdata,   // pos_x, pos_y, heading
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ddo_pkg::IDX_W-1:0] cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0] cfg_data
);
  import ddo_pkg::*;

  logic [CFG_W-1:0] dist_per_pulse;
  logic [CFG_W-1:0] turn_gain;
  logic             push;
  delta_t           push_data;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  delta_t           q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_pulse <= DIST_PER_PULSE_RST;
      turn_gain      <= TURN_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIST_PER_PULSE: dist_per_pulse <= cfg_data;
        REG_TURN_GAIN:      turn_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  ddo_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .q_full, .push, .push_data
  );

  ddo_queue u_queue (
    .clk, .rst, .push, .push_data, .full(q_full),
    .pop, .q_valid, .q_data
  );

  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .q_valid, .q_data, .pop,
    .dist_per_pulse, .turn_gain,
    .m_tvalid, .m_tready, .m_tdata
  );

endmodule

// ===== dv/tb_differential_drive_odometry.sv =====
// testbench for differential_drive_odometry: drives encoder count pairs, predicts the pose
// in fixed point and checks every output pose field by field; uses ddo_pkg
`timescale 1ns / 100ps

module tb_differential_drive_odometry;
  import ddo_pkg::*;

  localparam int unsigned STEPS = CORDIC_STEPS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hd;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  differential_drive_odometry dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [23:0] dpp_q, gain_q;
  logic [31:0] prev_l, prev_r, xq, yq, thq;
  pose_t pose_q[$];

  int errors = 0;
  int idle_cycles = 0;
  bit rx_gaps = 1'b1;
  bit tx_gaps = 1'b1;
  bit hold_rx = 1'b0;

  function automatic void predictor_reset();
    dpp_q = DIST_PER_PULSE_RST;
    gain_q = TURN_GAIN_RST;
    prev_l = '0; prev_r = '0; xq = '0; yq = '0; thq = '0;
  endfunction

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void sincos(logic [31:0] ang, output longint c, output longint s);
    logic [31:0] sh;
    logic [1:0] quad;
    longint z, x, y, nx, sx, sy;
    sh = ang + EIGHTH_TURN;
    quad = sh[31:30];
    z = longint'({2'b00, sh[29:0]}) - longint'(EIGHTH_TURN);
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      sx = asr(x, i);
      sy = asr(y, i);
      if (z >= 0) begin
        nx = x - sy; y = y + sx; z = z - longint'(atan_lut(5'(i)));
      end else begin
        nx = x + sy; y = y - sx; z = z + longint'(atan_lut(5'(i)));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic void predict_pose(logic [31:0] l, logic [31:0] r);
    longint dl, dr, mean, diff, c, s;
    logic [63:0] turn, px, py;
    pose_t p;
    dl = longint'($signed(l - prev_l));
    dr = longint'($signed(r - prev_r));
    prev_l = l;
    prev_r = r;
    mean = asr((dl + dr) * longint'(dpp_q), 17);
    diff = asr((dr - dl) * longint'(dpp_q), 16);
    turn = 64'(diff) * 64'(gain_q);
    sincos(thq + turn[32:1], c, s);
    px = 64'(mean) * 64'(c);
    py = 64'(mean) * 64'(s);
    xq = xq + px[61:30];
    yq = yq + py[61:30];
    thq = thq + turn[31:0];
    p.px = xq; p.py = yq; p.hd = thq;
    pose_q.push_back(p);
  endfunction

  // tvalid stays high after a request so back to back requests need no gap;
  // a gap or drain() takes it low
  task automatic send_counts(logic [31:0] l, logic [31:0] r);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tdata <= {r, l};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_pose(l, r);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DIST_PER_PULSE) dpp_q = val;
    else if (idx == REG_TURN_GAIN) gain_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (STEPS + 16) @(negedge clk);
  endtask

  // receiver with random stall bursts and one long hold-off
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_rx) m_tready <= 1'b0;
    else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    pose_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pose_q.size() == 0) begin
        $error("pose with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (m_tdata[31:0] !== e.px) begin
          $error("pos_x expected %0d got %0d", e.px, $signed(m_tdata[31:0])); errors++;
        end
        if (m_tdata[63:32] !== e.py) begin
          $error("pos_y expected %0d got %0d", e.py, $signed(m_tdata[63:32])); errors++;
        end
        if (m_tdata[95:64] !== e.hd) begin
          $error("heading expected %h got %h", e.hd, m_tdata[95:64]); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake on input, output or config, outside the hold-off
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || hold_rx)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_differential_drive_odometry: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_counts(32'd1000, 32'd1000);
    send_counts(32'd1000, 32'd1500);
    send_counts(32'd1500, 32'd1000);
    send_counts(32'hFFFF_FFF0, 32'h0000_0010);      // left count wraps below zero
    send_counts(32'h7FFF_FFF0, 32'h8000_0010);      // jump of half the range
    send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_counts(32'h0, 32'h0);
    send_counts(32'h8000_0000, 32'h0);
    send_counts(32'h0, 32'h8000_0000);
    send_counts(32'h5555_5555, 32'hAAAA_AAAA);
    send_counts(32'hAAAA_AAAA, 32'h5555_5555);
    drain();
    write_reg(REG_DIST_PER_PULSE, 24'hFF_FFFF);
    write_reg(REG_TURN_GAIN, 24'hFF_FFFF);
    write_reg(8'hFF, 24'h12_3456);                  // out of range, ignored
    send_counts(32'h7FFF_FFFF, 32'h8000_0000);
    send_counts(32'h0, 32'hFFFF_FFFF);
    send_counts(32'h1234_5678, 32'h1234_5000);
    drain();
    write_reg(REG_DIST_PER_PULSE, 24'h0);
    write_reg(REG_TURN_GAIN, 24'h0);
    send_counts(32'h0, 32'h4000_0000);
    drain();
  endtask

  task automatic test_random(int n);
    logic [31:0] l, r;
    l = prev_l; r = prev_r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        l = $urandom; r = $urandom;
      end else begin
        l = l + 32'($signed(11'($urandom)));
        r = r + 32'($signed(11'($urandom)));
      end
      send_counts(l, r);
    end
  endtask

  task automatic test_config_sweep();
    logic [23:0] dv[4] = '{24'd661425, 24'd1, 24'h80_0000, 24'hFF_FFFF};
    logic [23:0] gv[4] = '{24'd45350, 24'hFF_FFFF, 24'd1, 24'd3000};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_DIST_PER_PULSE, dv[k]);
      write_reg(REG_TURN_GAIN, gv[k]);
      test_random(250);
      drain();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
      end
      test_random(12);
    join
    drain();
    test_random(5);
    drain();                                         // sender pauses for all poses
  endtask

  initial begin
    predictor_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    write_reg(REG_DIST_PER_PULSE, 24'($urandom_range(0, 24'hFF_FFFF)));
    write_reg(REG_TURN_GAIN, 24'($urandom_range(0, 24'hFFFF)));
    test_random(600);
    rx_gaps = 1'b0;
    tx_gaps = 1'b0;
    test_random(200);
    drain();
    if (errors == 0)
      $display("tb_differential_drive_odometry: done, clean");
    else
      $display("tb_differential_drive_odometry: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ddo_pkg.sv
rtl/ddo_front.sv
rtl/ddo_queue.sv
rtl/ddo_back.sv
rtl/differential_drive_odometry.sv
dv/tb_differential_drive_odometry.sv
